// File: src/svs_pkg.sv
package svs_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                  found;
        logic                  changed;
        logic [POSITION_W-1:0] position;
        logic [COUNT_W-1:0]    count;
        logic [STATUS_W-1:0]   status;
    } result_t;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_ctrl_t;

endpackage

// File: src/sorted_value_set.sv
// Sorted value set: one command per transfer, one result per command.
// The start transfer sets busy; the result strobe (done) is registered from
// busy and is high for exactly one cycle; the receiver cannot stall. A new
// command is accepted only while busy is low (busy is high for the compare
// and shift cycle of the cell chain). Reset clears the count and control
// state at once; stored values are never read before they are written.
module sorted_value_set #(
    parameter int CAPACITY   = svs_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = svs_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  svs_pkg::item_t   item,
    output logic             done,
    output svs_pkg::result_t result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  busy_reg;
    logic                  done_reg;
    svs_pkg::cmd_t         cmd_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    svs_pkg::result_t      result_reg;
    svs_pkg::result_t      result_next;

    logic [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic [CAPACITY-1:0]   bound_vec;
    logic [IDX_W-1:0]      eq_idx;
    logic [IDX_W-1:0]      ins_idx;
    logic [IDX_W-1:0]      pos_idx;
    logic [IDX_W+svs_pkg::POSITION_W-1:0] pos_ext;
    logic [CNT_W+svs_pkg::COUNT_W-1:0]    cnt_ext;
    logic [VALUE_BITS+svs_pkg::VALUE_W-1:0] key_ext;

    logic                  key_zero;
    logic                  present;
    logic                  full;
    svs_pkg::cell_ctrl_t   ctrl;

    assign key_ext  = {{VALUE_BITS{1'b0}}, item.value};
    assign key_zero = (key_reg == '0);
    assign present  = (|eq_vec) && !key_zero;
    assign full     = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl.do_insert = 1'b0;
        ctrl.do_remove = 1'b0;
        unique case (cmd_reg)
            svs_pkg::CMD_INSERT:
            begin
                ctrl.do_insert = busy_reg && !key_zero && !present && !full;
            end
            svs_pkg::CMD_REMOVE:
            begin
                ctrl.do_remove = busy_reg && present;
            end
            default:
            begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                  occ;
            logic                  lt_prev;
            logic [VALUE_BITS-1:0] value_prev;
            logic [VALUE_BITS-1:0] value_succ;

            assign occ = (count_reg > CNT_W'(g));

            if (g == 0)
            begin : g_first
                assign lt_prev    = 1'b1;
                assign value_prev = key_reg;
            end
            else
            begin : g_mid
                assign lt_prev    = lt_vec[g-1];
                assign value_prev = cell_val[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign value_succ = cell_val[g];
            end
            else
            begin : g_inner
                assign value_succ = cell_val[g+1];
            end

            assign bound_vec[g] = lt_prev && !lt_vec[g];

            svs_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (key_reg),
                .occupied   (occ),
                .lt_prev    (lt_prev),
                .value_prev (value_prev),
                .value_succ (value_succ),
                .value      (cell_val[g]),
                .lt         (lt_vec[g]),
                .eq         (eq_vec[g])
            );
        end
    endgenerate

    svs_enc #(
        .N     (CAPACITY),
        .IDX_W (IDX_W)
    ) u_enc_eq (
        .onehot (eq_vec),
        .index  (eq_idx)
    );

    svs_enc #(
        .N     (CAPACITY),
        .IDX_W (IDX_W)
    ) u_enc_ins (
        .onehot (bound_vec),
        .index  (ins_idx)
    );

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd_reg == svs_pkg::CMD_CLEAR && busy_reg)
        begin
            count_next = '0;
        end
    end

    assign pos_idx = ctrl.do_insert ? ins_idx : eq_idx;
    assign pos_ext = {{svs_pkg::POSITION_W{1'b0}}, pos_idx};
    assign cnt_ext = {{svs_pkg::COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        result_next.found    = present && (cmd_reg != svs_pkg::CMD_CLEAR);
        result_next.changed  = ctrl.do_insert || ctrl.do_remove
                             || (cmd_reg == svs_pkg::CMD_CLEAR && count_reg != '0);
        result_next.position = '0;
        if (ctrl.do_insert || result_next.found)
        begin
            result_next.position = pos_ext[svs_pkg::POSITION_W-1:0];
        end
        result_next.count  = cnt_ext[svs_pkg::COUNT_W-1:0];
        result_next.status = svs_pkg::ST_OK;
        if (cmd_reg == svs_pkg::CMD_INSERT)
        begin
            if (key_zero)
            begin
                result_next.status = svs_pkg::ST_ZERO;
            end
            else if (!present && full)
            begin
                result_next.status = svs_pkg::ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= start && !busy_reg;
            done_reg  <= busy_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            cmd_reg <= svs_pkg::cmd_t'(item.cmd);
            key_reg <= key_ext[VALUE_BITS-1:0];
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: src/svs_cell.sv
module svs_cell #(
    parameter int VALUE_BITS = svs_pkg::VALUE_BITS_DEF
) (
    input  logic                   clk,
    input  svs_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]  key,
    input  logic                   occupied,
    input  logic                   lt_prev,
    input  logic [VALUE_BITS-1:0]  value_prev,
    input  logic [VALUE_BITS-1:0]  value_succ,
    output logic [VALUE_BITS-1:0]  value,
    output logic                   lt,
    output logic                   eq
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    assign value = value_reg;
    assign lt    = occupied && (value_reg < key);
    assign eq    = occupied && (value_reg == key);

    // Cells at or above the target position move: up on insert, down on remove
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.do_insert && !lt)
        begin
            value_next = lt_prev ? key : value_prev;
        end
        else if (ctrl.do_remove && !lt)
        begin
            value_next = value_succ;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: src/svs_enc.sv
module svs_enc #(
    parameter int N     = svs_pkg::CAPACITY_DEF,
    parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]     onehot,
    output logic [IDX_W-1:0] index
);

    always_comb
    begin
        index = '0;
        for (int i = 0; i < N; i++)
        begin
            if (onehot[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

endmodule

// File: tb/sorted_value_set_checker.sv
`timescale 1ns / 1ps

module sorted_value_set_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  svs_pkg::item_t   item,
    input  logic             done,
    input  svs_pkg::result_t result,
    output int               fails,
    output int               pending
);
    import svs_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    logic [VALUE_W-1:0] members [DEPTH];
    int                 member_count;
    result_t            awaited_results [$];
    result_t            want;

    // Applies one command to the shadow set and returns the result it causes.
    function automatic result_t apply_command(input item_t it);
        result_t            r;
        int                 idx;
        logic               hit;
        logic [VALUE_W-1:0] v;
        v   = it.value;
        r   = '0;
        idx = 0;
        while (idx < member_count && members[idx] < v)
            idx++;
        hit = (v != '0) && (idx < member_count) && (members[idx] == v);
        case (cmd_t'(it.cmd))
            CMD_INSERT:
            begin
                if (v == '0)
                    r.status = ST_ZERO;
                else if (hit)
                begin
                    r.found    = 1'b1;
                    r.position = idx[POSITION_W-1:0];
                end
                else if (member_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = member_count; k > idx; k--)
                        members[k] = members[k-1];
                    members[idx] = v;
                    member_count++;
                    r.changed  = 1'b1;
                    r.position = idx[POSITION_W-1:0];
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    for (int k = idx; k + 1 < member_count; k++)
                        members[k] = members[k+1];
                    member_count--;
                    r.found    = 1'b1;
                    r.changed  = 1'b1;
                    r.position = idx[POSITION_W-1:0];
                end
            end
            CMD_CONTAINS:
            begin
                if (hit)
                begin
                    r.found    = 1'b1;
                    r.position = idx[POSITION_W-1:0];
                end
            end
            default:
            begin
                r.changed    = (member_count != 0);
                member_count = 0;
            end
        endcase
        r.count = member_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count = 0;
            awaited_results.delete();
            fails   = 0;
            pending = 0;
            for (int k = 0; k < DEPTH; k++)
                members[k] = '0;
        end
        else
        begin
            // results belong to earlier transfers, so retire before pushing
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: result with nothing awaited: %p", $realtime, result);
                    fails++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.found !== result.found || want.changed !== result.changed
                        || want.position !== result.position || want.count !== result.count
                        || want.status !== result.status)
                    begin
                        if (fails < 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, result);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_command(item));
            pending = awaited_results.size();
        end
    end

endmodule

// File: tb/sorted_value_set_test.sv
`timescale 1ns / 1ps

module sorted_value_set_test;
    import svs_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int POOL_SIZE  = 24;
    localparam int BLOCKS     = 15;
    localparam int BLOCK_LEN  = 50;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    item_t              item;
    result_t            result;
    int                 fails;
    int                 pending;
    int                 idle_cycles = 0;
    logic [VALUE_W-1:0] pool [POOL_SIZE];

    sorted_value_set dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    sorted_value_set_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sorted_value_set_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(input cmd_t c, input logic [VALUE_W-1:0] v);
        item.cmd   = c;
        item.value = v;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n)
            begin
                item.cmd   = CMD_W'($urandom_range(0, 3));
                item.value = $urandom;
                @(negedge clk);
            end
        end
    endtask

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return pool[$urandom_range(0, POOL_SIZE-1)];
        else if (r < 80)
            return $urandom;
        else if (r < 85)
            return '0;
        else if (r < 90)
            return '1;
        else if (r < 95)
            return 32'd1;
        return $urandom_range(1, 255);
    endfunction

    task automatic fill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = $urandom;
    endtask

    initial
    begin
        int   mode;
        int   r;
        bit   quiet;
        cmd_t c;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        send(CMD_INSERT, '0);
        send(CMD_CLEAR, '0);
        send(CMD_REMOVE, '0);
        send(CMD_CONTAINS, 32'd5);
        send(CMD_INSERT, '1);
        send(CMD_INSERT, 32'd1);
        pause(gap_len(1'b0));
        send(CMD_INSERT, 32'd1);
        send(CMD_CONTAINS, '1);
        send(CMD_REMOVE, 32'd3);
        send(CMD_REMOVE, '1);
        // fill to capacity, inserting downward so every insert after the first shifts
        for (int i = 14; i >= 1; i--)
        begin
            send(CMD_INSERT, i * 32'h1111_1111);
            pause(gap_len(1'b0));
        end
        send(CMD_INSERT, 32'h8000_0000);
        send(CMD_INSERT, 32'd2);
        send(CMD_INSERT, 32'd1);
        send(CMD_CLEAR, $urandom);

        // random
        fill_pool();
        for (int b = 0; b < BLOCKS; b++)
        begin
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            if (b % 4 == 3)
                fill_pool();
            for (int n = 0; n < BLOCK_LEN; n++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0:       c = r < 75 ? CMD_INSERT : r < 85 ? CMD_REMOVE
                               : r < 99 ? CMD_CONTAINS : CMD_CLEAR;
                    1:       c = r < 40 ? CMD_INSERT : r < 70 ? CMD_REMOVE
                               : r < 97 ? CMD_CONTAINS : CMD_CLEAR;
                    default: c = r < 15 ? CMD_INSERT : r < 65 ? CMD_REMOVE
                               : r < 95 ? CMD_CONTAINS : CMD_CLEAR;
                endcase
                send(c, pick_value());
                pause(gap_len(quiet));
            end
        end
        start = 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("sorted_value_set_test: PASS");
        else
            $display("sorted_value_set_test: FAIL");
        $finish;
    end

endmodule
